FILE: hw/rtl/u2c_pkg.sv
// Shared types, constants and a lookup function for the UTF-8 to CP866 printer transcoder.
// No dependencies; u2c_front, u2c_cmdq, u2c_back and the top level use it by scoped names.
package u2c_pkg;

    localparam int unsigned NUM_USER = 18;

    localparam logic [7:0] ESC_BYTE      = 8'h1B;
    localparam logic [7:0] USER_MODE_CMD = 8'h25;
    localparam logic [7:0] USER_MODE_ON  = 8'h01;
    localparam logic [7:0] USER_MODE_OFF = 8'h00;
    localparam logic [7:0] CHR_SPACE     = 8'h20;
    localparam logic [7:0] CHR_D         = 8'h64;
    localparam logic [7:0] CHR_APOS      = 8'h27;
    localparam logic [7:0] CHR_COMMA     = 8'h2C;
    localparam logic [7:0] CP866_IO      = 8'hF0;
    localparam logic [7:0] LEAD_CYR_LO   = 8'hD0;
    localparam logic [7:0] LEAD_CYR_HI   = 8'hD1;
    localparam logic [7:0] CYR_OFS_A     = 8'h70;
    localparam logic [7:0] CYR_OFS_B     = 8'hA0;
    localparam logic [4:0] IDX_EZH       = 5'd14;

    localparam logic [10:0] U_CYR_A_LO = 11'h410;
    localparam logic [10:0] U_CYR_A_HI = 11'h43F;
    localparam logic [10:0] U_CYR_B_LO = 11'h440;
    localparam logic [10:0] U_CYR_B_HI = 11'h44F;
    localparam logic [10:0] U_CYR_YO   = 11'h451;
    localparam logic [10:0] U_CYR_IO   = 11'h401;
    localparam logic [10:0] U_DZH      = 11'h2A4;
    localparam logic [10:0] U_STRESS_P = 11'h2C8;
    localparam logic [10:0] U_STRESS_S = 11'h2CC;

    localparam logic [10:0] USER_POINTS [NUM_USER] = '{
        11'h23E, 11'h0E6, 11'h0F0, 11'h14B, 11'h251, 11'h252, 11'h254, 11'h259, 11'h25B,
        11'h25C, 11'h26A, 11'h283, 11'h28A, 11'h28C, 11'h292, 11'h2A7, 11'h2D0, 11'h3B8
    };

    // Register indexes on the configuration port
    localparam logic REG_USER_BASE = 1'b0;
    localparam logic REG_FALLBACK  = 1'b1;

    // Last byte position of each command kind
    localparam logic [2:0] LAST_ONE  = 3'd0;
    localparam logic [2:0] LAST_TWO  = 3'd1;
    localparam logic [2:0] LAST_USER = 3'd6;
    localparam logic [2:0] LAST_DZH  = 3'd7;

    typedef enum logic [1:0] {
        K_ONE,
        K_TWO,
        K_USER,
        K_DZH
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] b0;   // single byte, first of a pair, or user character
        logic [7:0] b1;   // second of a pair
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic await_second;
        logic skip_space;
    } t_front_stat;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } t_user_hit;

    function automatic t_user_hit user_lookup(input logic [10:0] u);
        t_user_hit r;
        r = '0;
        for (int i = NUM_USER - 1; i >= 0; i--) begin
            if (USER_POINTS[i] == u) begin
                r.hit = 1'b1;
                r.idx = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/u2c_if.sv
// Stream interfaces for the transcoder: input bytes and printer bytes.
// Depends on nothing; used by u2c_front, u2c_back and the top level.
interface u2c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface u2c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       last;
    modport source (output valid, output byte_out, output last, input ready);
    modport sink (input valid, input byte_out, input last, output ready);
endinterface

FILE: hw/rtl/u2c_front.sv
// Front end: accepts UTF-8 bytes, tracks lead and space-skip state, classifies into commands.
// Depends on u2c_pkg and u2c_in_if.
module u2c_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    u2c_in_if.sink               i_in,
    input  logic [7:0]           i_base,
    input  logic [7:0]           i_fallback,
    input  logic                 i_full,
    output logic                 o_push,
    output u2c_pkg::t_cmd        o_cmd,
    output u2c_pkg::t_front_stat o_stat
);

    logic [7:0] r_lead, n_lead;
    logic       r_await, n_await;
    logic       r_skip, n_skip;

    logic                 accept;
    logic [7:0]           b;
    logic [10:0]          u;
    u2c_pkg::t_user_hit   hit;
    u2c_pkg::t_cmd        sec_cmd;
    logic                 sec_dzh;
    logic [7:0]           cyr;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.byte_in;
    assign u          = {r_lead[4:0], b[5:0]};
    assign hit        = u2c_pkg::user_lookup(u);

    // Cyrillic code point to CP866
    always_comb begin
        if (u >= u2c_pkg::U_CYR_A_LO && u <= u2c_pkg::U_CYR_A_HI) begin
            cyr = u[7:0] + u2c_pkg::CYR_OFS_A;
        end else if ((u >= u2c_pkg::U_CYR_B_LO && u <= u2c_pkg::U_CYR_B_HI)
                     || u == u2c_pkg::U_CYR_YO) begin
            cyr = u[7:0] + u2c_pkg::CYR_OFS_B;
        end else if (u == u2c_pkg::U_CYR_IO) begin
            cyr = u2c_pkg::CP866_IO;
        end else begin
            cyr = i_fallback;
        end
    end

    // Classify a completed two-byte sequence
    always_comb begin
        sec_cmd.kind = u2c_pkg::K_ONE;
        sec_cmd.b0   = cyr;
        sec_cmd.b1   = b;
        sec_dzh      = 1'b0;
        if (r_lead == u2c_pkg::LEAD_CYR_LO || r_lead == u2c_pkg::LEAD_CYR_HI) begin
            sec_cmd.b0 = cyr;
        end else if (u == u2c_pkg::U_DZH) begin
            sec_cmd.kind = u2c_pkg::K_DZH;
            sec_cmd.b0   = i_base + {3'b000, u2c_pkg::IDX_EZH};
            sec_dzh      = 1'b1;
        end else if (u == u2c_pkg::U_STRESS_P) begin
            sec_cmd.b0 = u2c_pkg::CHR_APOS;
        end else if (u == u2c_pkg::U_STRESS_S) begin
            sec_cmd.b0 = u2c_pkg::CHR_COMMA;
        end else if (hit.hit) begin
            sec_cmd.kind = u2c_pkg::K_USER;
            sec_cmd.b0   = i_base + {3'b000, hit.idx};
        end else begin
            sec_cmd.kind = u2c_pkg::K_TWO;
            sec_cmd.b0   = r_lead;
        end
    end

    always_comb begin
        n_lead  = r_lead;
        n_await = r_await;
        n_skip  = r_skip;
        o_push  = 1'b0;
        o_cmd   = sec_cmd;
        if (accept) begin
            if (r_skip) begin
                n_skip = 1'b0;
            end
            if (r_skip && b == u2c_pkg::CHR_SPACE) begin
                // drop the space after the dzh ligature
            end else if (r_await) begin
                n_await = 1'b0;
                o_push  = 1'b1;
                if (sec_dzh) begin
                    n_skip = 1'b1;
                end
            end else if (b[7:5] == 3'b110) begin
                n_lead  = b;
                n_await = 1'b1;
            end else begin
                o_push       = 1'b1;
                o_cmd.kind   = u2c_pkg::K_ONE;
                o_cmd.b0     = b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= '0;
            r_await <= 1'b0;
            r_skip  <= 1'b0;
        end else begin
            r_lead  <= n_lead;
            r_await <= n_await;
            r_skip  <= n_skip;
        end
    end

    assign o_stat.await_second = r_await;
    assign o_stat.skip_space   = r_skip;

endmodule

FILE: hw/rtl/u2c_cmdq.sv
// Two-entry command queue between front end and output sequencer.
// Depends on u2c_pkg.
module u2c_cmdq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u2c_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output u2c_pkg::t_cmd    o_head,
    output u2c_pkg::t_q_stat o_stat
);

    u2c_pkg::t_cmd r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = r_cnt[1];
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

FILE: hw/rtl/u2c_back.sv
// Output sequencer: expands queue head into an output register, one printer byte per unstalled cycle.
// Depends on u2c_pkg and u2c_out_if.
module u2c_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u2c_pkg::t_cmd    i_head,
    input  u2c_pkg::t_q_stat i_qstat,
    output logic             o_pop,
    u2c_out_if.source        o_out
);

    logic [2:0] r_pos;
    logic       r_ov;
    logic [7:0] r_ob;
    logic       r_ol;

    logic       adv;
    logic [2:0] last_pos;
    logic [2:0] upos;
    logic       is_last;
    logic [7:0] ubyte;
    logic [7:0] nbyte;

    assign adv = !i_qstat.empty && (!r_ov || o_out.ready);

    always_comb begin
        case (i_head.kind)
            u2c_pkg::K_ONE:  last_pos = u2c_pkg::LAST_ONE;
            u2c_pkg::K_TWO:  last_pos = u2c_pkg::LAST_TWO;
            u2c_pkg::K_USER: last_pos = u2c_pkg::LAST_USER;
            default:         last_pos = u2c_pkg::LAST_DZH;
        endcase
    end

    assign is_last = (r_pos == last_pos);
    assign upos    = (i_head.kind == u2c_pkg::K_DZH) ? r_pos - 3'd1 : r_pos;

    // User character escape sequence
    always_comb begin
        case (upos)
            3'd0:    ubyte = u2c_pkg::ESC_BYTE;
            3'd1:    ubyte = u2c_pkg::USER_MODE_CMD;
            3'd2:    ubyte = u2c_pkg::USER_MODE_ON;
            3'd3:    ubyte = i_head.b0;
            3'd4:    ubyte = u2c_pkg::ESC_BYTE;
            3'd5:    ubyte = u2c_pkg::USER_MODE_CMD;
            default: ubyte = u2c_pkg::USER_MODE_OFF;
        endcase
    end

    always_comb begin
        case (i_head.kind)
            u2c_pkg::K_ONE:  nbyte = i_head.b0;
            u2c_pkg::K_TWO:  nbyte = (r_pos == 3'd0) ? i_head.b0 : i_head.b1;
            u2c_pkg::K_USER: nbyte = ubyte;
            default:         nbyte = (r_pos == 3'd0) ? u2c_pkg::CHR_D : ubyte;
        endcase
    end

    assign o_pop = adv && is_last;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ob <= nbyte;
            r_ol <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (adv) begin
                r_ov  <= 1'b1;
                r_pos <= is_last ? 3'd0 : r_pos + 3'd1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.byte_out = r_ob;
    assign o_out.last     = r_ol;

endmodule

FILE: hw/rtl/utf8_to_cp866_printer_transcoder.sv
// Top level of the UTF-8 to CP866 printer transcoder: APB registers, front end, queue, sequencer.
// Depends on u2c_pkg, u2c_if, u2c_front, u2c_cmdq and u2c_back.
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        byte_in[7:0]
//  o_out     out  valid/ready        byte_out[7:0], last
//  apb       in   psel/penable/...   paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
// An input byte yields zero to eight printer bytes; the output sequencer emits one byte per
// cycle while o_out.ready allows; a byte yields none (held lead, dropped space), one (plain
// byte, Cyrillic letter, stress mark), two (unmatched pair), seven (user character) or eight
// (affricate) printer bytes. The front end takes a byte every cycle while the two-entry queue
// has room, also while the output register waits on o_out.ready.
// Reset is synchronous and active low; it clears the decoder state, the queue and the output
// valid, and loads user_char_base = 33 and fallback_char = 63.
module utf8_to_cp866_printer_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u2c_in_if.sink      i_in,
    u2c_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_base;
    logic [7:0] r_fallback;

    logic                 push;
    logic                 pop;
    u2c_pkg::t_cmd        push_cmd;
    u2c_pkg::t_cmd        head_cmd;
    u2c_pkg::t_q_stat     q_stat;
    u2c_pkg::t_front_stat f_stat;
    logic                 wr_en;

    // Configuration registers: write on the access phase, select by word address
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= 8'd33;
            r_fallback <= 8'd63;
        end else if (wr_en) begin
            if (paddr[2] == u2c_pkg::REG_USER_BASE) begin
                r_base <= pwdata[7:0];
            end else begin
                r_fallback <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == u2c_pkg::REG_FALLBACK) ? {24'd0, r_fallback}
                                                        : {24'd0, r_base};

    // Front end: classify input bytes into output commands
    u2c_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_base     (r_base),
        .i_fallback (r_fallback),
        .i_full     (q_stat.full),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .o_stat     (f_stat)
    );

    // Decouple front end from the byte sequencer
    u2c_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    // Back end: expand commands into printer bytes
    u2c_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_cmd),
        .i_qstat (q_stat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("command pushed into full queue");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // A held lead byte and a pending space drop never coexist
    a_state_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(f_stat.await_second && f_stat.skip_space))
        else $error("lead held while space skip pending");

    // A popped command ends with a last byte in the output register
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (o_out.valid && o_out.last))
        else $error("command retired without last byte");

endmodule

FILE: sim/tb_utf8_to_cp866_printer_transcoder.sv
`timescale 1ns / 1ps
// Self-checking bench for the UTF-8 to CP866 printer transcoder: a byte-level scoreboard
// predicts every printer byte. Depends on u2c_pkg, u2c_if and the transcoder RTL.

import u2c_pkg::*;

typedef struct packed {
    logic [7:0] code;
    logic       last;
} printer_byte_t;

// Tracks the decoder state and the register copies, and holds the printer bytes still due
class printer_byte_board;
    localparam logic [10:0] CYR_BLOCK = 11'h400;
    localparam logic [2:0]  LEAD2_TAG = 3'b110;
    localparam int          MAX_REPORTS = 40;

    printer_byte_t due[$];
    logic [7:0]    burst[$];
    logic [7:0]    user_base;
    logic [7:0]    fallback;
    logic [7:0]    held_lead;
    bit            lead_held;
    bit            drop_space;
    int            errors;
    int            bytes_in;
    int            bytes_out;

    function new();
        user_base  = 8'd33;
        fallback   = 8'd63;
        held_lead  = 8'd0;
        lead_held  = 1'b0;
        drop_space = 1'b0;
        errors     = 0;
        bytes_in   = 0;
        bytes_out  = 0;
    endfunction

    function void write_reg(logic idx, logic [7:0] value);
        if (idx == REG_USER_BASE) begin
            user_base = value;
        end else begin
            fallback = value;
        end
    endfunction

    // Frame user character idx with the escape sequences that switch user mode on and off
    function void add_user(logic [4:0] idx);
        burst.push_back(ESC_BYTE);
        burst.push_back(USER_MODE_CMD);
        burst.push_back(USER_MODE_ON);
        burst.push_back(user_base + 8'(idx));
        burst.push_back(ESC_BYTE);
        burst.push_back(USER_MODE_CMD);
        burst.push_back(USER_MODE_OFF);
    endfunction

    function void take_utf8_byte(logic [7:0] b);
        logic [10:0]   u;
        bit            matched;
        printer_byte_t entry;
        burst.delete();
        bytes_in++;
        if (drop_space) begin
            drop_space = 1'b0;
            if (b == CHR_SPACE) begin
                return;
            end
        end
        if (lead_held) begin
            lead_held = 1'b0;
            // the second byte is never checked for the continuation tag
            u = {held_lead[4:0], b[5:0]};
            if (held_lead == LEAD_CYR_LO || held_lead == LEAD_CYR_HI) begin
                if (u >= U_CYR_A_LO && u <= U_CYR_A_HI) begin
                    burst.push_back(8'(u - CYR_BLOCK) + CYR_OFS_A);
                end else if ((u >= U_CYR_B_LO && u <= U_CYR_B_HI) || u == U_CYR_YO) begin
                    burst.push_back(8'(u - CYR_BLOCK) + CYR_OFS_B);
                end else if (u == U_CYR_IO) begin
                    burst.push_back(CP866_IO);
                end else begin
                    burst.push_back(fallback);
                end
            end else if (u == U_DZH) begin
                burst.push_back(CHR_D);
                add_user(IDX_EZH);
                drop_space = 1'b1;
            end else if (u == U_STRESS_P) begin
                burst.push_back(CHR_APOS);
            end else if (u == U_STRESS_S) begin
                burst.push_back(CHR_COMMA);
            end else begin
                matched = 1'b0;
                for (int i = 0; i < NUM_USER; i++) begin
                    if (!matched && USER_POINTS[i] == u) begin
                        add_user(5'(i));
                        matched = 1'b1;
                    end
                end
                if (!matched) begin
                    burst.push_back(held_lead);
                    burst.push_back(b);
                end
            end
        end else if (b[7:5] == LEAD2_TAG) begin
            held_lead = b;
            lead_held = 1'b1;
        end else begin
            burst.push_back(b);
        end
        foreach (burst[i]) begin
            entry.code = burst[i];
            entry.last = (i == burst.size() - 1);
            due.push_back(entry);
        end
    endfunction

    function void check_printer_byte(logic [7:0] code, logic last);
        printer_byte_t want;
        bytes_out++;
        if (due.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: unexpected printer byte %02h (last %0b)", $time, code, last);
            return;
        end
        want = due.pop_front();
        if (want.code !== code) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: byte_out expected %02h, got %02h", $time, want.code, code);
        end
        if (want.last !== last) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: last expected %0b, got %0b (byte %02h)",
                         $time, want.last, last, code);
        end
    endfunction
endclass

module tb_utf8_to_cp866_printer_transcoder;

    // Longest quiet stretch in a correct run is the drain pause or a gap plus a stall;
    // the limit is many times that.
    localparam int          WATCHDOG_LIMIT = 2000;
    // Cycles to wait once nothing is due: a held lead or a dropped space yields nothing,
    // so give the front end and the two-entry queue time to go quiet.
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          RANDOM_BYTES   = 112;
    localparam logic [1:0]  CONT_TAG       = 2'b10;
    localparam logic [10:0] U_E_ACUTE      = 11'h0E9;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    u2c_in_if  in_bus ();
    u2c_out_if out_bus ();

    utf8_to_cp866_printer_transcoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    printer_byte_board board = new();
    logic [7:0]        utf8_text[$];
    bit                calm = 1'b0;  // both sides run without gaps or stalls
    int                idle_cycles = 0;
    int                settings_used = 1;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Append one code point as a two-byte UTF-8 sequence
    function automatic void add_point(logic [10:0] u);
        utf8_text.push_back({3'b110, u[10:6]});
        utf8_text.push_back({CONT_TAG, u[5:0]});
    endfunction

    // Build mostly well-formed text: Cyrillic, IPA user characters, the affricate with and
    // without its trailing space, stress marks, plus stray and broken sequences as noise.
    function automatic void add_random_text(int count);
        int          target;
        int          pick;
        logic [10:0] u;
        target = utf8_text.size() + count;
        while (utf8_text.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                utf8_text.push_back(8'($urandom_range(0, 127)));
            end else if (pick < 22) begin
                utf8_text.push_back(CHR_SPACE);
            end else if (pick < 42) begin
                utf8_text.push_back($urandom_range(0, 1) ? LEAD_CYR_HI : LEAD_CYR_LO);
                utf8_text.push_back({CONT_TAG, 6'($urandom)});
            end else if (pick < 47) begin
                utf8_text.push_back($urandom_range(0, 1) ? LEAD_CYR_HI : LEAD_CYR_LO);
                utf8_text.push_back(8'($urandom));
            end else if (pick < 62) begin
                add_point(USER_POINTS[$urandom_range(0, NUM_USER - 1)]);
            end else if (pick < 70) begin
                add_point(U_DZH);
                if ($urandom_range(0, 1))
                    utf8_text.push_back(CHR_SPACE);
            end else if (pick < 75) begin
                add_point($urandom_range(0, 1) ? U_STRESS_S : U_STRESS_P);
            end else if (pick < 85) begin
                u = 11'($urandom);
                add_point(u);
            end else if (pick < 93) begin
                utf8_text.push_back(8'($urandom_range(128, 255)));
            end else begin
                utf8_text.push_back(8'($urandom));
            end
        end
    endfunction

    // Send the queued text; entered and left at a falling edge
    task automatic send_text();
        int gap;
        foreach (utf8_text[k]) begin
            gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                in_bus.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            in_bus.valid   = 1'b1;
            in_bus.byte_in = utf8_text[k];
            do @(posedge i_clk); while (!in_bus.ready);
            board.take_utf8_byte(utf8_text[k]);
            @(negedge i_clk);
        end
        in_bus.valid = 1'b0;
        utf8_text.delete();
    endtask

    // APB write: setup cycle, then access cycle; the register loads when pready is seen
    task automatic set_register(logic idx, logic [7:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {24'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Wait until every predicted byte has come out, then let the block go quiet
    task automatic settle();
        while (board.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic reconfigure(logic [7:0] base, logic [7:0] fallback);
        set_register(REG_USER_BASE, base);
        set_register(REG_FALLBACK, fallback);
        settings_used++;
    endtask

    // Printer side: stall a random number of cycles before each byte, then take it
    initial begin
        int stall;
        out_bus.ready = 1'b0;
        forever begin
            stall = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                out_bus.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_bus.ready = 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && out_bus.valid));
            board.check_printer_byte(out_bus.byte_out, out_bus.last);
            @(negedge i_clk);
        end
    end

    // Watchdog: end the run if nothing moves on any port for too long
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("utf8_to_cp866_printer_transcoder: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.byte_in = 8'd0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 3'd0;
        pwdata         = 32'd0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed text at the reset settings: ASCII extremes, Cyrillic range edges and
        // Io, an unmapped Cyrillic point, a non-continuation second byte, the first and
        // last user characters, the affricate with a dropped and a kept follower, both
        // stress marks, an unmatched pair, stray high bytes and a lead taken as second byte.
        utf8_text.push_back(8'h00);
        utf8_text.push_back(8'h7F);
        add_point(U_CYR_A_LO);
        add_point(U_CYR_A_HI);
        add_point(U_CYR_B_HI);
        add_point(U_CYR_YO);
        add_point(U_CYR_IO);
        utf8_text.push_back(LEAD_CYR_HI);
        utf8_text.push_back(8'hFF);
        add_point(USER_POINTS[0]);
        add_point(USER_POINTS[NUM_USER - 1]);
        add_point(U_DZH);
        utf8_text.push_back(CHR_SPACE);
        add_point(U_DZH);
        utf8_text.push_back(8'h41);
        add_point(U_STRESS_P);
        add_point(U_STRESS_S);
        add_point(U_E_ACUTE);
        utf8_text.push_back(8'h80);
        utf8_text.push_back(8'hFF);
        utf8_text.push_back(8'hC5);
        utf8_text.push_back(LEAD_CYR_LO);
        send_text();
        settle();

        // Extremes of both registers, low then high, user codes wrap past 255
        reconfigure(8'h00, 8'h00);
        add_random_text(RANDOM_BYTES);
        send_text();
        settle();

        reconfigure(8'hFF, 8'hFF);
        add_random_text(RANDOM_BYTES);
        send_text();
        settle();

        reconfigure(8'($urandom), 8'($urandom));
        add_random_text(RANDOM_BYTES);
        send_text();
        settle();

        // Last stretch at full rate on both sides
        calm = 1'b1;
        reconfigure(8'($urandom), 8'($urandom));
        add_random_text(RANDOM_BYTES);
        send_text();
        settle();

        if (board.due.size() != 0) begin
            board.errors++;
            $display("%0t: %0d printer bytes never arrived", $time, board.due.size());
        end
        $display("Sent %0d UTF-8 bytes under %0d register settings, checked %0d printer bytes.",
                 board.bytes_in, settings_used, board.bytes_out);
        $display("Errors found: %0d", board.errors);
        if (board.errors == 0) begin
            $display("utf8_to_cp866_printer_transcoder: match");
        end else begin
            $display("utf8_to_cp866_printer_transcoder: mismatch");
        end
        $finish;
    end

endmodule
